/* design/twtm_pkg.sv */
// ----------------------------------------------------------------------------
// twtm_pkg
// Shared constants for the trimmed window temperature mean block.
// ----------------------------------------------------------------------------
package twtm_pkg;

    localparam int SAMPLE_W    = 12;   // raw sample, 1/16 degree
    localparam int MEAN_W      = 15;   // mean, 1/100 degree
    localparam int HELD_W      = 4;    // reported count width
    localparam int RAW_SHIFT   = 4;    // raw units per degree = 2**RAW_SHIFT
    localparam int CENTI       = 100;  // output units per degree
    localparam int CENTI_W     = 7;    // bits needed for CENTI
    localparam int TRIM_MIN    = 2;    // trim only when more than this are held
    localparam int DEPTH_DEF   = 8;

endpackage

/* design/twtm_window.sv */
// ----------------------------------------------------------------------------
// twtm_window
// Ring store of the last DEPTH good samples, with fill count and one
// registered read port for the scan.
// ----------------------------------------------------------------------------
module twtm_window
    import twtm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic signed [SAMPLE_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr,
    output logic signed [SAMPLE_W-1:0] o_rd_data,
    output logic [CNT_W-1:0]           o_fill
);

    logic signed [SAMPLE_W-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]              r_slot;
    logic [CNT_W-1:0]           r_fill;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[r_slot] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
        end else if (i_wr_en) begin
            if (r_slot == AW'(DEPTH - 1)) begin
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + 1'b1;
            end
            if (r_fill != CNT_W'(DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_fill = r_fill;

endmodule

/* design/twtm_div.sv */
// ----------------------------------------------------------------------------
// twtm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twtm_div
    import twtm_pkg::*;
#(
    parameter int N_W = 23,
    parameter int D_W = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quot
);

    localparam int CW = $clog2(N_W + 1);

    logic [D_W-1:0] r_rem;
    logic [N_W-1:0] r_quot;
    logic [D_W-1:0] r_dvs;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [D_W:0]   rem_sh;
    logic [D_W:0]   rem_sub;
    logic           take;

    always_comb begin
        rem_sh  = {r_rem, r_quot[N_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        take    = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N_W);
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= take ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
                r_quot <= {r_quot[N_W-2:0], take};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* design/trimmed_window_temperature_mean.sv */
// ----------------------------------------------------------------------------
// trimmed_window_temperature_mean
// Trimmed moving mean of temperature samples in hundredths of a degree.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry i_sample (signed 1/16 degree)
// and i_sample_ok. A good sample enters a ring of the last DEPTH samples; a
// bad one leaves the ring alone. Every input word gives one output word.
// Output channel: o_out_valid / i_out_ready carry o_mean_centi, o_held_count
// and o_has_value. With more than two samples held, one largest and one
// smallest are dropped before the mean is taken.
// One word at a time: o_in_ready is low from acceptance until the result is
// loaded into the output register. The time taken is set by the scan (one
// store read per cycle) and the divider (one quotient bit per cycle, over an
// N-bit dividend, N = sample width + count width + 7, 23 at DEPTH 8).
// The output register holds a result until taken; a finished result waits
// for a stalled receiver before the next input word is taken.
// Reset empties the window and clears both valid flags; the store itself
// needs no clearing pass.
// ----------------------------------------------------------------------------
module trimmed_window_temperature_mean
    import twtm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_sample_ok,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [MEAN_W-1:0]   o_mean_centi,
    output logic [HELD_W-1:0]          o_held_count,
    output logic                       o_has_value
);

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int PROD_W = SUM_W + CENTI_W;
    localparam int DIV_W  = CNT_W + RAW_SHIFT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM,
        S_SCALE,
        S_DIV,
        S_OUT
    } t_state;

    t_state                     r_state;
    logic [CNT_W-1:0]           r_k;
    logic                       r_rd_vld;
    logic                       r_first;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_top;
    logic signed [SAMPLE_W-1:0] r_bot;
    logic [CNT_W-1:0]           r_n;
    logic                       r_neg;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_div_start;
    logic                       r_out_valid;
    logic signed [MEAN_W-1:0]   r_mean;
    logic [HELD_W-1:0]          r_held;
    logic                       r_has;

    logic                       accept;
    logic [AW-1:0]              rd_addr;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic [CNT_W-1:0]           fill;
    logic                       div_done;
    logic [PROD_W-1:0]          quot;
    logic signed [SUM_W-1:0]    trimmed;
    logic [SUM_W-1:0]           mag;
    logic signed [MEAN_W-1:0]   q_short;

    assign accept  = i_in_valid && o_in_ready;
    assign rd_addr = r_k[AW-1:0];
    assign trimmed = r_sum - SUM_W'(r_top) - SUM_W'(r_bot);
    assign mag     = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign q_short = MEAN_W'(quot);

    twtm_window #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CNT_W (CNT_W)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && i_sample_ok),
        .i_wr_data (i_sample),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_fill    (fill)
    );

    twtm_div #(
        .N_W (PROD_W),
        .D_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_prod),
        .i_divisor  ({r_n, RAW_SHIFT'(0)}),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_SCALE) && (r_n != '0);
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state  <= S_SCAN;
                        r_k      <= '0;
                        r_rd_vld <= 1'b0;
                        r_first  <= 1'b1;
                        r_sum    <= '0;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= (r_k < fill);
                    if (r_k < fill) begin
                        r_k <= r_k + 1'b1;
                    end
                    if (r_rd_vld) begin
                        r_first <= 1'b0;
                        r_sum   <= r_sum + SUM_W'(rd_data);
                        if (r_first || rd_data > r_top) begin
                            r_top <= rd_data;
                        end
                        if (r_first || rd_data < r_bot) begin
                            r_bot <= rd_data;
                        end
                    end else if (!(r_k < fill)) begin
                        r_state <= S_TRIM;
                    end
                end
                S_TRIM: begin
                    if (32'(fill) > TRIM_MIN) begin
                        r_sum <= trimmed;
                        r_n   <= fill - CNT_W'(TRIM_MIN);
                    end else begin
                        r_n   <= fill;
                    end
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_neg  <= r_sum[SUM_W-1];
                    r_prod <= PROD_W'(mag) * PROD_W'(CENTI);
                    if (r_n == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_held      <= HELD_W'(fill);
                        r_has       <= (fill != '0);
                        if (fill == '0) begin
                            r_mean <= '0;
                        end else begin
                            r_mean <= r_neg ? -q_short : q_short;
                        end
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_mean_centi = r_mean;
    assign o_held_count = r_held;
    assign o_has_value  = r_has;

endmodule

/* design/twtm_checker.sv */
// ----------------------------------------------------------------------------
// twtm_checker
// Port-level checks for trimmed_window_temperature_mean, bound to the top.
// ----------------------------------------------------------------------------
module twtm_checker
    import twtm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [MEAN_W-1:0]   o_mean_centi,
    input logic [HELD_W-1:0]          o_held_count,
    input logic                       o_has_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_mean_centi)
            && $stable(o_held_count) && $stable(o_has_value)))
        else $error("output word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again while a word is in work");

    a_has_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && DEPTH <= 15) |-> (o_has_value == (o_held_count != '0)))
        else $error("has_value disagrees with held_count");

    a_empty_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_value) |-> (o_mean_centi == '0))
        else $error("mean nonzero with empty window");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && DEPTH <= 15) |-> (o_held_count <= HELD_W'(DEPTH)))
        else $error("held_count beyond depth");

endmodule

bind trimmed_window_temperature_mean twtm_checker #(.DEPTH(DEPTH)) u_twtm_checker (.*);

/* dv/trimmed_window_temperature_mean_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_window_temperature_mean_tb
// Self-checking bench for the trimmed window temperature mean block.
// A queue-fed driver offers sample words with random gaps. A monitor takes
// result words with random stalls and one long hold-off. Each result word is
// checked against a model of the ring, the trim and the scaled division.
// ----------------------------------------------------------------------------
module trimmed_window_temperature_mean_tb;
    import twtm_pkg::*;

    localparam int WIN_DEPTH = DEPTH_DEF;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] raw;
        logic                       good;
    } t_reading;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [HELD_W-1:0]        held;
        logic                     has;
    } t_summary;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_sample_ok = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [MEAN_W-1:0]   o_mean_centi;
    logic [HELD_W-1:0]          o_held_count;
    logic                       o_has_value;

    trimmed_window_temperature_mean #(.DEPTH(WIN_DEPTH)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_sample_ok  (i_sample_ok),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_mean_centi (o_mean_centi),
        .o_held_count (o_held_count),
        .o_has_value  (o_has_value)
    );

    always #4 i_clk = ~i_clk;

    t_reading reading_q[$];
    t_summary mean_expect_q[$];

    logic signed [SAMPLE_W-1:0] ring_hist [WIN_DEPTH];
    int       ring_fill = 0;
    int       ring_slot = 0;
    int       error_count = 0;
    int       words_seen = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    int       hold_left = 0;
    bit       long_hold_done = 1'b0;
    bit       calm = 1'b0;
    int       room_base = 0;
    t_reading next_word;
    t_summary want;

    // Ring update plus trimmed mean for one accepted word
    function automatic t_summary trimmed_mean_of_window(input t_reading rd);
        t_summary res;
        int total;
        int top;
        int bottom;
        int n;
        int v;
        total = 0;
        top = 0;
        bottom = 0;
        res = '0;
        if (rd.good) begin
            ring_hist[ring_slot] = rd.raw;
            ring_slot = (ring_slot + 1 >= WIN_DEPTH) ? 0 : ring_slot + 1;
            if (ring_fill < WIN_DEPTH) ring_fill++;
        end
        for (int k = 0; k < ring_fill; k++) begin
            v = int'(ring_hist[k]);
            if (k == 0 || v > top) top = v;
            if (k == 0 || v < bottom) bottom = v;
            total += v;
        end
        n = ring_fill;
        if (n > TRIM_MIN) begin
            total = total - top - bottom;
            n -= 2;
        end
        if (n > 0) begin
            res.mean = MEAN_W'((total * CENTI) / (n * (1 << RAW_SHIFT)));
            res.has  = 1'b1;
        end
        res.held = HELD_W'(ring_fill);
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("mismatch @%0t: %s", $time, what);
    endtask

    task automatic queue_reading(input int raw, input bit good);
        t_reading rd;
        rd.raw  = SAMPLE_W'(raw);
        rd.good = good;
        reading_q.push_back(rd);
    endtask

    function automatic t_reading pick_reading();
        t_reading rd;
        int mode;
        mode = $urandom_range(0, 9);
        if ($urandom_range(0, 24) == 0) room_base = $urandom_range(0, 4000) - 2000;
        case (mode)
            0: begin
                rd.raw = SAMPLE_W'($urandom);
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: rd.raw = SAMPLE_W'(-2048);
                    1: rd.raw = SAMPLE_W'(2047);
                    2: rd.raw = SAMPLE_W'(0);
                    default: rd.raw = SAMPLE_W'(-1);
                endcase
            end
            default: begin
                rd.raw = SAMPLE_W'(room_base + $urandom_range(0, 80) - 40);
            end
        endcase
        rd.good = ($urandom_range(0, 6) != 0);
        return rd;
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (reading_q.size() != 0 || mean_expect_q.size() != 0 || i_in_valid);
    endtask

    // Sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_sample    <= '0;
            i_sample_ok <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                mean_expect_q.push_back(trimmed_mean_of_window({i_sample, i_sample_ok}));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (reading_q.size() > 0) begin
                    next_word = reading_q.pop_front();
                    i_sample    <= next_word.raw;
                    i_sample_ok <= next_word.good;
                    i_in_valid  <= 1'b1;
                    if (!calm && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 11);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                words_seen++;
                if (mean_expect_q.size() == 0) begin
                    flag_mismatch("result word with nothing expected");
                end else begin
                    want = mean_expect_q.pop_front();
                    if (o_mean_centi !== want.mean)
                        flag_mismatch($sformatf("mean_centi %0d, want %0d",
                                                o_mean_centi, want.mean));
                    if (o_held_count !== want.held)
                        flag_mismatch($sformatf("held_count %0d, want %0d",
                                                o_held_count, want.held));
                    if (o_has_value !== want.has)
                        flag_mismatch($sformatf("has_value %0b, want %0b",
                                                o_has_value, want.has));
                end
            end
            if (!long_hold_done && words_seen >= 120) begin
                long_hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) hold_left--;
            else if (stall_left > 0) stall_left--;
            else if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
            i_out_ready <= (hold_left == 0 && stall_left == 0);
        end
    end

    initial begin
        // empty window, extremes, trim start, duplicates, wrap, bad words
        queue_reading(2047, 1'b0);
        queue_reading(-2048, 1'b1);
        queue_reading(2047, 1'b1);
        queue_reading(0, 1'b1);
        queue_reading(-1, 1'b1);
        queue_reading(1, 1'b1);
        queue_reading(2047, 1'b1);
        queue_reading(2047, 1'b1);
        queue_reading(-2048, 1'b1);
        queue_reading(12'h555, 1'b1);
        queue_reading(-1366, 1'b1);
        queue_reading(5, 1'b0);
        for (int k = 0; k < 8; k++) queue_reading(-2048, 1'b1);
        for (int k = 0; k < 4; k++) queue_reading(2047, 1'b1);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        for (int k = 0; k < 420; k++) reading_q.push_back(pick_reading());
        wait_drained();
        for (int k = 0; k < 280; k++) reading_q.push_back(pick_reading());
        wait_drained();
        calm = 1'b1;
        for (int k = 0; k < 150; k++) reading_q.push_back(pick_reading());
        wait_drained();
        repeat (60) @(posedge i_clk);

        if (error_count == 0) begin
            $display("trimmed_window_temperature_mean_tb: PASS");
        end else begin
            $display("trimmed_window_temperature_mean_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("trimmed_window_temperature_mean_tb: FAIL");
        $finish;
    end

endmodule

/* trimmed_window_temperature_mean.f */
design/twtm_pkg.sv
design/twtm_window.sv
design/twtm_div.sv
design/trimmed_window_temperature_mean.sv
design/twtm_checker.sv
dv/trimmed_window_temperature_mean_tb.sv
